[rtl/core/bpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// control word layout, step program and datapath constants of the banded
// pid controller
// ----------------------------------------------------------------------------
package bpc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_MS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_ENABLE = 3'd7;

    localparam logic [15:0] SAMPLE_MS_RESET = 16'd100;
    localparam logic signed [15:0] POS_RESET = 16'sh8000;
    localparam logic signed [15:0] DRIVE_MAX = 16'sh7fff;
    localparam logic signed [15:0] DRIVE_MIN = 16'sh8000;

    // datapath widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 40;
    localparam int INT_W   = 48;

    // division by 1000 as a shift by 3 and a radix-16 division by 125
    localparam int DIVISOR    = 125;
    localparam int PRE_SHIFT  = 3;
    localparam int DIV_DIGITS = 11;
    localparam int QUO_W      = 4 * DIV_DIGITS;
    localparam int REM_W      = 7;
    localparam int PART_W     = REM_W + 4;
    localparam int CNT_W      = $clog2(DIV_DIGITS + 1);

    // step counter
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;
    localparam pc_t PC_IDLE   = 4'd0;
    localparam pc_t PC_BAND   = 4'd1;
    localparam pc_t PC_PROP   = 4'd2;
    localparam pc_t PC_SCALE  = 4'd3;
    localparam pc_t PC_LOAD   = 4'd4;
    localparam pc_t PC_DERIV  = 4'd5;
    localparam pc_t PC_DIV    = 4'd6;
    localparam pc_t PC_ISUM   = 4'd7;
    localparam pc_t PC_CLAMP  = 4'd8;
    localparam pc_t PC_COMMIT = 4'd9;
    localparam pc_t PC_EMIT   = 4'd10;
    localparam pc_t PC_FULL   = 4'd11;

    typedef logic [1:0] mul_a_t;
    localparam mul_a_t MA_PGAIN = 2'd0;
    localparam mul_a_t MA_IGAIN = 2'd1;
    localparam mul_a_t MA_DGAIN = 2'd2;
    localparam mul_a_t MA_PROD  = 2'd3;

    typedef logic [1:0] mul_b_t;
    localparam mul_b_t MB_ERR    = 2'd0;
    localparam mul_b_t MB_DIFF   = 2'd1;
    localparam mul_b_t MB_PERIOD = 2'd2;

    typedef logic [2:0] acc_op_t;
    localparam acc_op_t ACC_NONE  = 3'd0;
    localparam acc_op_t ACC_CLEAR = 3'd1;
    localparam acc_op_t ACC_PROD  = 3'd2;
    localparam acc_op_t ACC_DERIV = 3'd3;
    localparam acc_op_t ACC_INTEG = 3'd4;

    typedef logic [1:0] div_op_t;
    localparam div_op_t DIV_NONE = 2'd0;
    localparam div_op_t DIV_LOAD = 2'd1;
    localparam div_op_t DIV_STEP = 2'd2;

    typedef logic [1:0] int_op_t;
    localparam int_op_t INT_NONE  = 2'd0;
    localparam int_op_t INT_SUM   = 2'd1;
    localparam int_op_t INT_CLAMP = 2'd2;

    typedef logic [1:0] emit_t;
    localparam emit_t EMIT_NONE = 2'd0;
    localparam emit_t EMIT_SUM  = 2'd1;
    localparam emit_t EMIT_FULL = 2'd2;

    typedef logic [2:0] cond_t;
    localparam cond_t C_NEVER    = 3'd0;
    localparam cond_t C_ALWAYS   = 3'd1;
    localparam cond_t C_IN_IDLE  = 3'd2;
    localparam cond_t C_OUT_BAND = 3'd3;
    localparam cond_t C_DIV_MORE = 3'd4;
    localparam cond_t C_OUT_BUSY = 3'd5;

    typedef struct packed {
        logic    in_ready;
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        div_op_t div_op;
        int_op_t int_op;
        logic    commit;
        emit_t   emit;
        cond_t   cond;
        pc_t     target;
        logic    last;
    } ctrl_word_t;

    // step program: a true condition jumps to target, otherwise the next
    // step follows, or idle after a last step
    function automatic ctrl_word_t rom_word(input pc_t pc);
        ctrl_word_t w;
        w = '0;
        case (pc)
            PC_IDLE:
            begin
                w.in_ready = 1'b1;
                w.cond     = C_IN_IDLE;
                w.target   = PC_IDLE;
            end
            PC_BAND:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_PGAIN;
                w.mul_b  = MB_ERR;
                w.acc_op = ACC_CLEAR;
                w.cond   = C_OUT_BAND;
                w.target = PC_FULL;
            end
            PC_PROP:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_IGAIN;
                w.mul_b  = MB_ERR;
                w.acc_op = ACC_PROD;
            end
            PC_SCALE:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_PROD;
                w.mul_b  = MB_PERIOD;
            end
            PC_LOAD:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_DGAIN;
                w.mul_b  = MB_DIFF;
                w.div_op = DIV_LOAD;
            end
            PC_DERIV:
            begin
                w.acc_op = ACC_DERIV;
                w.div_op = DIV_STEP;
            end
            PC_DIV:
            begin
                w.div_op = DIV_STEP;
                w.cond   = C_DIV_MORE;
                w.target = PC_DIV;
            end
            PC_ISUM:
            begin
                w.int_op = INT_SUM;
            end
            PC_CLAMP:
            begin
                w.int_op = INT_CLAMP;
            end
            PC_COMMIT:
            begin
                w.acc_op = ACC_INTEG;
                w.commit = 1'b1;
            end
            PC_EMIT:
            begin
                w.emit   = EMIT_SUM;
                w.cond   = C_OUT_BUSY;
                w.target = PC_EMIT;
                w.last   = 1'b1;
            end
            PC_FULL:
            begin
                w.emit   = EMIT_FULL;
                w.cond   = C_OUT_BUSY;
                w.target = PC_FULL;
                w.last   = 1'b1;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/core/banded_pid_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banded_pid_controller_unit
// pid controller with error band and clamped integral, run by a step program
// ----------------------------------------------------------------------------
// inside the band a sample runs through band, prop, scale, load, deriv, the
//   divide loop, isum, clamp, commit and emit; outside it band jumps to full;
//   emit and full wait while the output is held; a new sample is taken only
//   in the next cycle after the result is written; the divide loop (11 digit
//   steps) and the shared multiplier, four products in turn, set the run length
// reset: rst_n clears all control state, config registers take their reset
//   values, integral sum is zero and no position history is held
// ----------------------------------------------------------------------------
module banded_pid_controller_unit #(
    parameter int SCALE_SHIFT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] error_value,
    input  logic signed [15:0] measured_pos,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] drive_out,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import bpc_pkg::*;

    // configuration
    logic signed [15:0] prop_gain_reg;
    logic signed [15:0] integ_gain_reg;
    logic [14:0]        error_band_reg;
    logic signed [15:0] integ_lower_reg;
    logic signed [15:0] integ_upper_reg;
    logic [15:0]        sample_ms_reg;
    logic signed [15:0] deriv_gain_reg;
    logic               deriv_enable_reg;

    // controller state
    logic signed [15:0] integ_sum_reg;
    logic signed [15:0] prev_pos_reg;
    logic               prev_valid_reg;

    // sequencer and datapath
    pc_t                       pc_reg;
    pc_t                       pc_next;
    ctrl_word_t                ctrl;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [15:0]        err_reg;
    logic signed [15:0]        pos_reg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_mag;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_shift;
    logic [QUO_W-1:0]          quo_reg;
    logic [REM_W-1:0]          rem_reg;
    logic                      neg_reg;
    logic [PART_W-1:0]         part;
    logic [3:0]                digit;
    logic [PART_W-1:0]         digit_mult;
    logic signed [INT_W-1:0]   integ_reg;
    logic signed [INT_W-1:0]   quo_signed;
    logic signed [INT_W-1:0]   upper_ext;
    logic signed [INT_W-1:0]   lower_ext;
    logic signed [16:0]        err_ext;
    logic signed [16:0]        band_ext;
    logic signed [16:0]        pos_diff;
    logic                      out_band;
    logic                      out_busy;
    logic                      cond_true;
    logic                      emit_write;
    logic                      out_valid_reg;
    logic signed [15:0]        drive_reg;
    logic signed [15:0]        drive_sum;

    assign ctrl      = rom_word(pc_reg);
    assign in_ready  = ctrl.in_ready;
    assign out_valid = out_valid_reg;
    assign drive_out = drive_reg;

    assign out_busy   = out_valid_reg && !out_ready;
    assign emit_write = (ctrl.emit != EMIT_NONE) && !out_busy;

    assign err_ext  = {err_reg[15], err_reg};
    assign band_ext = {2'b00, error_band_reg};
    assign out_band = (err_ext > band_ext) || (err_ext < -band_ext);
    assign pos_diff = {prev_pos_reg[15], prev_pos_reg} - {pos_reg[15], pos_reg};

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_IN_IDLE:  cond_true = !in_valid;
            C_OUT_BAND: cond_true = out_band;
            C_DIV_MORE: cond_true = cnt_reg != CNT_W'(1);
            C_OUT_BUSY: cond_true = out_busy;
            default:    cond_true = 1'b0;
        endcase
        if (cond_true)
            pc_next = ctrl.target;
        else if (ctrl.last)
            pc_next = PC_IDLE;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    // shared multiplier operands
    always_comb
    begin
        case (ctrl.mul_a)
            MA_PGAIN: mul_a = MUL_A_W'(prop_gain_reg);
            MA_IGAIN: mul_a = MUL_A_W'(integ_gain_reg);
            MA_DGAIN: mul_a = MUL_A_W'(deriv_gain_reg);
            MA_PROD:  mul_a = prod_reg[MUL_A_W-1:0];
            default:  mul_a = '0;
        endcase
        case (ctrl.mul_b)
            MB_ERR:    mul_b = err_ext;
            MB_DIFF:   mul_b = pos_diff;
            MB_PERIOD: mul_b = {1'b0, sample_ms_reg};
            default:   mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_mag  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    // one radix-16 digit of the division by 125
    assign part = {rem_reg, quo_reg[QUO_W-1 -: 4]};

    always_comb
    begin
        digit = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (part >= PART_W'(k * DIVISOR))
                digit = 4'(k);
        end
        digit_mult = PART_W'(digit) * PART_W'(DIVISOR);
    end

    assign quo_signed = neg_reg ? -$signed({{(INT_W-QUO_W){1'b0}}, quo_reg})
                                :  $signed({{(INT_W-QUO_W){1'b0}}, quo_reg});
    assign upper_ext  = INT_W'(integ_upper_reg);
    assign lower_ext  = INT_W'(integ_lower_reg);

    assign acc_shift = acc_reg >>> SCALE_SHIFT;

    always_comb
    begin
        if (acc_shift > ACC_W'(DRIVE_MAX))
            drive_sum = DRIVE_MAX;
        else if (acc_shift < ACC_W'(DRIVE_MIN))
            drive_sum = DRIVE_MIN;
        else
            drive_sum = acc_shift[15:0];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            error_band_reg   <= '0;
            integ_lower_reg  <= '0;
            integ_upper_reg  <= '0;
            sample_ms_reg    <= SAMPLE_MS_RESET;
            deriv_gain_reg   <= '0;
            deriv_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PROP_GAIN:    prop_gain_reg    <= cfg_data;
                REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data;
                REG_ERROR_BAND:   error_band_reg   <= cfg_data[14:0];
                REG_INTEG_LOWER:  integ_lower_reg  <= cfg_data;
                REG_INTEG_UPPER:  integ_upper_reg  <= cfg_data;
                REG_SAMPLE_MS:    sample_ms_reg    <= cfg_data;
                REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data;
                REG_DERIV_ENABLE: deriv_enable_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // sequencer, controller state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= PC_IDLE;
            cnt_reg        <= '0;
            integ_sum_reg  <= '0;
            prev_pos_reg   <= POS_RESET;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (ctrl.div_op == DIV_LOAD)
                cnt_reg <= CNT_W'(DIV_DIGITS);
            else if (ctrl.div_op == DIV_STEP)
                cnt_reg <= cnt_reg - CNT_W'(1);
            if (ctrl.commit)
            begin
                integ_sum_reg <= integ_reg[15:0];
                if (deriv_enable_reg)
                begin
                    prev_pos_reg   <= pos_reg;
                    prev_valid_reg <= 1'b1;
                end
                else
                begin
                    prev_valid_reg <= 1'b0;
                end
            end
            if (emit_write)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.in_ready)
        begin
            err_reg <= error_value;
            pos_reg <= measured_pos;
        end
        if (ctrl.mul_en)
            prod_reg <= prod_next;

        case (ctrl.acc_op)
            ACC_CLEAR: acc_reg <= '0;
            ACC_PROD:  acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            ACC_DERIV:
            begin
                if (deriv_enable_reg && prev_valid_reg)
                    acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            end
            ACC_INTEG: acc_reg <= acc_reg + ACC_W'($signed(integ_reg[15:0]));
            default:   ;
        endcase

        // magnitude over 8 by shift, then long division by 125
        case (ctrl.div_op)
            DIV_LOAD:
            begin
                neg_reg <= prod_reg[PROD_W-1];
                quo_reg <= prod_mag[PRE_SHIFT +: QUO_W];
                rem_reg <= '0;
            end
            DIV_STEP:
            begin
                quo_reg <= {quo_reg[QUO_W-5:0], digit};
                rem_reg <= REM_W'(part - digit_mult);
            end
            default: ;
        endcase

        case (ctrl.int_op)
            INT_SUM: integ_reg <= INT_W'(integ_sum_reg) + quo_signed;
            INT_CLAMP:
            begin
                // when the bounds cross, a value above the upper bound takes it, any other the lower
                if (integ_reg > upper_ext)
                    integ_reg <= upper_ext;
                else if (integ_reg < lower_ext)
                    integ_reg <= lower_ext;
            end
            default: ;
        endcase

        if (emit_write)
        begin
            if (ctrl.emit == EMIT_FULL)
                drive_reg <= err_reg[15] ? DRIVE_MIN : DRIVE_MAX;
            else
                drive_reg <= drive_sum;
        end
    end

endmodule
